>>> sv/esv_pkg.sv
// Package for the signature checker: shared types and constants.
// Used by esv_mulmod and the top level elgamal_signature_verify.
package esv_pkg;

    // Operation codes for the modular multiply unit.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_MUL  = 2'd1
    } t_op;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_MODULUS    = 2'd0;
    localparam logic [1:0] REG_GENERATOR  = 2'd1;
    localparam logic [1:0] REG_PUBLIC_KEY = 2'd2;

endpackage

>>> sv/elgamal_signature_verify.sv
// Top level of the signature checker: configuration, sequencer and result register.
// Depends on esv_pkg and esv_mulmod.
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | i_message, i_sig_first, i_sig_second
//  output  | out       | o_valid / i_stall    | o_valid_res
//  config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Each modular multiplication is launched by the sequencer and then waits on the single
// shared multiplier. A transaction needs at most 3 * (2 * WIDTH + 1) + 1 of them (a base
// reduction, then a multiply and a square per exponent bit for each of the three powers,
// then the final product), fewer for short exponents.
// Reset is synchronous and active low; configuration returns to modulus 2, others 0.
// The input is stalled from acceptance until the result transaction has been taken.
module elgamal_signature_verify #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [WIDTH-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_message,
    input  logic [WIDTH-1:0] i_sig_first,
    input  logic [WIDTH-1:0] i_sig_second,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_valid_res
);
    import esv_pkg::*;

    localparam int EW = $clog2(WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_REDW, S_POW, S_MULA, S_MULAW, S_SQ, S_SQW,
        S_NEXT, S_FIN, S_FINW, S_OUT
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_gen;
    logic [WIDTH-1:0] r_pub;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_s1;
    logic [WIDTH-1:0] r_s2;
    logic [1:0]       r_pass;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_exp;
    logic [EW-1:0]    r_bits;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_v1;
    logic [WIDTH-1:0] r_v2;
    logic             r_res;
    logic             r_valid;
    logic             r_start;
    logic [WIDTH-1:0] r_mx;
    logic [WIDTH-1:0] r_my;
    logic             w_done;
    logic [WIDTH-1:0] w_p;
    logic [WIDTH-1:0] w_one;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WIDTH'(2);
            r_gen <= '0;
            r_pub <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:    r_mod <= i_cfg_data;
                REG_GENERATOR:  r_gen <= i_cfg_data;
                REG_PUBLIC_KEY: r_pub <= i_cfg_data;
                default: ;
            endcase
        end
    end

    esv_mulmod #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_m     (r_mod),
        .o_done  (w_done),
        .o_p     (w_p)
    );

    // One mod q is 1 for q of 2 or more.
    assign w_one = WIDTH'(1);

    // Sequencer: three powers, then the product and compare; a modulus below 2 fails at once.
    // Base reduction uses the multiplier with x = 1 and y = base: the double-and-add walk
    // over the bits of y then yields base mod q for any base of WIDTH bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_start <= 1'b0;
            r_pass  <= '0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_m  <= i_message;
                        r_s1 <= i_sig_first;
                        r_s2 <= i_sig_second;
                        r_pass <= 2'd0;
                        if (r_mod < WIDTH'(2)) begin
                            r_res   <= 1'b0;
                            r_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_base  <= r_gen;
                            r_exp   <= i_message;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    // Launch the reduction of the base modulo q.
                    r_mx    <= w_one;
                    r_my    <= r_base;
                    r_start <= 1'b1;
                    r_state <= S_REDW;
                end
                S_REDW: begin
                    if (w_done) begin
                        r_sq    <= w_p;
                        r_acc   <= w_one;
                        r_bits  <= EW'(WIDTH);
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (r_bits == '0 || r_exp == '0) begin
                        r_state <= S_NEXT;
                    end else if (r_exp[0]) begin
                        r_mx    <= r_acc;
                        r_my    <= r_sq;
                        r_start <= 1'b1;
                        r_state <= S_MULAW;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_MULA: r_state <= S_MULAW;
                S_MULAW: begin
                    if (w_done) begin
                        r_acc   <= w_p;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_mx    <= r_sq;
                    r_my    <= r_sq;
                    r_start <= 1'b1;
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    if (w_done) begin
                        r_sq    <= w_p;
                        r_exp   <= r_exp >> 1;
                        r_bits  <= r_bits - 1'b1;
                        r_state <= S_POW;
                    end
                end
                S_NEXT: begin
                    unique case (r_pass)
                        2'd0: begin
                            r_v1   <= r_acc;
                            r_base <= r_pub;
                            r_exp  <= r_s1;
                            r_pass <= 2'd1;
                            r_state <= S_RED;
                        end
                        2'd1: begin
                            r_v2   <= r_acc;
                            r_base <= r_s1;
                            r_exp  <= r_s2;
                            r_pass <= 2'd2;
                            r_state <= S_RED;
                        end
                        default: begin
                            r_mx    <= r_v2;
                            r_my    <= r_acc;
                            r_start <= 1'b1;
                            r_state <= S_FINW;
                        end
                    endcase
                end
                S_FIN: r_state <= S_FINW;
                S_FINW: begin
                    if (w_done) begin
                        r_res   <= (w_p == r_v1);
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_valid_res = r_res;

`ifndef SYNTHESIS
    // A result is only offered in the output state.
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_OUT)) else $error("result valid outside output state");
    // A taken result returns the block to idle.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall) |=> (r_state == S_IDLE)) else $error("no return to idle");
    // The multiplier is started only while the block is busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_REDW || r_state == S_MULAW || r_state == S_SQW ||
                     r_state == S_FINW))
        else $error("multiplier started while idle");
`endif

endmodule

>>> sv/esv_mulmod.sv
// Bit-serial modular multiplier: (x * y) mod m by double-and-add, one bit a cycle.
// Depends on esv_pkg. Operands must already be below m.
module esv_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_p
);
    import esv_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;
    logic             r_done;
    logic [WIDTH-1:0] n_dbl;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_sum2;

    // Doubling step and optional add of x, each reduced by one compare and subtract.
    always_comb begin
        w_sum = {1'b0, r_acc} + {1'b0, r_acc};
        if (w_sum >= {1'b0, r_m}) begin
            n_dbl = WIDTH'(w_sum - {1'b0, r_m});
        end else begin
            n_dbl = w_sum[WIDTH-1:0];
        end
        w_sum2 = {1'b0, n_dbl} + {1'b0, r_x};
        if (!r_y[WIDTH-1]) begin
            n_acc = n_dbl;
        end else if (w_sum2 >= {1'b0, r_m}) begin
            n_acc = WIDTH'(w_sum2 - {1'b0, r_m});
        end else begin
            n_acc = w_sum2[WIDTH-1:0];
        end
    end

    // Sequencer: one multiplier bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= r_y << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule
